// ===== rtl/ppg_window_peak_interval_unit_assert.svh =====
// Assertion macros shared by the PPG window peak interval unit.
`ifndef PPG_WINDOW_PEAK_INTERVAL_UNIT_ASSERT_SVH
`define PPG_WINDOW_PEAK_INTERVAL_UNIT_ASSERT_SVH

// Checks a property on every clock edge outside reset.
`define PWPI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a condition holds in the cycle after a trigger.
`define PWPI_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/pwpi_pkg.sv =====
// Shared types and constants of the PPG window peak interval unit.
package pwpi_pkg;

  localparam int unsigned SampleW = 16;
  localparam int unsigned AccW    = 32;
  localparam int unsigned GainW   = 16;
  localparam int unsigned CountW  = 12;
  localparam int unsigned SlopeW  = 17;
  localparam int unsigned RunW    = 2;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 16;

  localparam logic [CfgIdxW-1:0] CFG_FILTER_GAIN   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_WINDOW_LENGTH = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_SPIKE_LIMIT   = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_RISE_NEEDED   = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_FALL_NEEDED   = 3'd4;

  localparam logic [GainW-1:0]   GainReset   = 16'd5243;
  localparam logic [CountW-1:0]  WindowReset = 12'd500;
  localparam logic [SampleW-1:0] SpikeReset  = 16'd255;
  localparam logic [RunW-1:0]    RunReset    = 2'd3;
  localparam logic [RunW-1:0]    RunMax      = 2'd3;
  localparam logic [CountW-1:0]  PeaksMax    = 12'd4095;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_UPD,
    ST_DIV,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

// ===== rtl/pwpi_mul.sv =====
// Bit-serial multiplier that scales the filter error by the Q0.16 gain.
module pwpi_mul (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic [pwpi_pkg::AccW-1:0]          diff_i,
  input  logic [pwpi_pkg::GainW-1:0]         gain_i,
  output logic [pwpi_pkg::AccW-1:0]          step_o,
  output pwpi_pkg::unit_stat_t               stat_o
);

  localparam int unsigned ProdW = pwpi_pkg::AccW + pwpi_pkg::GainW;

  logic [ProdW-1:0]              prod_q, prod_d;
  logic [pwpi_pkg::AccW-1:0]     diff_q;
  logic [pwpi_pkg::GainW-1:0]    gain_q, gain_d;
  logic [4:0]                    cnt_q, cnt_d;
  logic                          busy_q, busy_d;
  logic                          done_q, done_d;

  always_comb begin
    prod_d = prod_q;
    gain_d = gain_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      prod_d = '0;
      gain_d = gain_i;
      cnt_d  = 5'(pwpi_pkg::GainW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      prod_d = {prod_q[ProdW-2:0], 1'b0} +
               (gain_q[pwpi_pkg::GainW-1] ? {{pwpi_pkg::GainW{1'b0}}, diff_q} : '0);
      gain_d = {gain_q[pwpi_pkg::GainW-2:0], 1'b0};
      cnt_d  = cnt_q - 5'd1;
      if (cnt_q == 5'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    gain_q <= gain_d;
    if (start_i) begin
      diff_q <= diff_i;
    end
  end

  assign step_o      = prod_q[ProdW-1:pwpi_pkg::GainW];
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

// ===== rtl/pwpi_div.sv =====
// Restoring divider, one quotient bit per cycle, for the mean peak spacing.
module pwpi_div (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic [pwpi_pkg::CountW-1:0]        dividend_i,
  input  logic [pwpi_pkg::CountW-1:0]        divisor_i,
  output logic [pwpi_pkg::CountW-1:0]        quotient_o,
  output pwpi_pkg::unit_stat_t               stat_o
);

  localparam int unsigned W = pwpi_pkg::CountW;

  logic [W-1:0] rem_q, rem_d;
  logic [W-1:0] quo_q, quo_d;
  logic [W-1:0] dvs_q;
  logic [W:0]   trial;
  logic         ge;
  logic [3:0]   cnt_q, cnt_d;
  logic         busy_q, busy_d;
  logic         done_q, done_d;

  always_comb begin
    trial  = {rem_q, quo_q[W-1]};
    ge     = trial >= {1'b0, dvs_q};
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      cnt_d  = 4'(W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? W'(trial - {1'b0, dvs_q}) : trial[W-1:0];
      quo_d = {quo_q[W-2:0], ge};
      cnt_d = cnt_q - 4'd1;
      if (cnt_q == 4'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) begin
      dvs_q <= divisor_i;
    end
  end

  assign quotient_o  = quo_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

// ===== rtl/ppg_window_peak_interval_unit.sv =====
// Top level of the PPG window peak interval unit: filter, slope, peak detector, window result.
//
//   channel | direction | handshake              | payload
//   input   | in        | in_valid_i / in_stall_o | sample_i
//   output  | out       | out_valid_o / out_stall_i | peak_count_o, mean_interval_o,
//           |           |                        | interval_valid_o
//   config  | in        | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// A sample is accepted, then passes through the bit-serial gain multiplier, then updates the
// slope and detector. The last sample of a window also passes through the serial divider
// when two or more peaks were found, and then loads the result register.
// The result register frees the input side; only a second result meeting a stalled first
// one waits. Reset clears the configuration to its defaults and starts an empty window.
module ppg_window_peak_interval_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [pwpi_pkg::SampleW-1:0]        sample_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [pwpi_pkg::CountW-1:0]         peak_count_o,
  output logic [pwpi_pkg::CountW-1:0]         mean_interval_o,
  output logic                                interval_valid_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [pwpi_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [pwpi_pkg::CfgDatW-1:0]        cfg_data_i
);

  localparam int unsigned AW = pwpi_pkg::AccW;
  localparam int unsigned SW = pwpi_pkg::SampleW;
  localparam int unsigned CW = pwpi_pkg::CountW;
  localparam int unsigned LW = pwpi_pkg::SlopeW;
  localparam int unsigned RW = pwpi_pkg::RunW;

  pwpi_pkg::state_e state_q, state_d;

  logic [pwpi_pkg::GainW-1:0] gain_q;
  logic [CW-1:0]              wlen_q;
  logic [SW-1:0]              spike_q;
  logic [RW-1:0]              rise_need_q, fall_need_q;

  logic [AW-1:0]        acc_q;
  logic                 up_q;
  logic [SW-1:0]        prev_smooth_q;
  logic signed [LW-1:0] prev_slope_q;
  logic [RW-1:0]        rise_q, fall_q;
  logic                 armed_q;
  logic [CW-1:0]        idx_q, peaks_q, first_q, last_q;
  logic [CW-1:0]        res_count_q;
  logic                 res_valid_q;

  logic                 out_valid_q;
  logic [CW-1:0]        out_count_q, out_mean_q;
  logic                 out_ivalid_q;

  logic [AW-1:0]        target, err_mag, mul_step;
  logic                 err_up;
  logic                 mul_start, div_start, emit_load, out_free;
  pwpi_pkg::unit_stat_t mul_stat, div_stat;
  logic [CW-1:0]        div_quo;

  logic [SW-1:0]        smooth;
  logic signed [LW-1:0] diff_s, slope;
  logic [LW-1:0]        mag;
  logic                 spike, pos, neg;
  logic [RW-1:0]        rise_goal, fall_goal, rise_inc, fall_inc;
  logic [RW-1:0]        rise_d, fall_d;
  logic                 armed_d;
  logic [CW-1:0]        peaks_d, first_d, last_d, span;
  logic                 win_end, multi;

  assign cfg_ready_o = 1'b1;

  assign target  = {sample_i, {(AW - SW){1'b0}}};
  assign err_up  = target >= acc_q;
  assign err_mag = err_up ? target - acc_q : acc_q - target;

  pwpi_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .diff_i  (err_mag),
    .gain_i  (gain_q),
    .step_o  (mul_step),
    .stat_o  (mul_stat)
  );

  always_comb begin
    smooth    = acc_q[AW-1:AW-SW];
    diff_s    = $signed({1'b0, smooth}) - $signed({1'b0, prev_smooth_q});
    mag       = diff_s[LW-1] ? LW'(-diff_s) : diff_s;
    spike     = mag >= {1'b0, spike_q};
    if (idx_q == '0) begin
      slope = '0;
    end else if (spike) begin
      slope = prev_slope_q;
    end else begin
      slope = diff_s;
    end
    pos       = !slope[LW-1] && (slope != '0);
    neg       = slope[LW-1];
    rise_goal = (rise_need_q == '0) ? RW'(1) : rise_need_q;
    fall_goal = (fall_need_q == '0) ? RW'(1) : fall_need_q;
    rise_inc  = (rise_q == pwpi_pkg::RunMax) ? rise_q : rise_q + RW'(1);
    fall_inc  = (fall_q == pwpi_pkg::RunMax) ? fall_q : fall_q + RW'(1);

    rise_d  = rise_q;
    fall_d  = fall_q;
    armed_d = armed_q;
    peaks_d = peaks_q;
    first_d = first_q;
    last_d  = last_q;
    if (pos && !armed_q) begin
      fall_d = '0;
      rise_d = rise_inc;
      if (rise_inc >= rise_goal) begin
        armed_d = 1'b1;
      end
    end else if (neg && armed_q) begin
      rise_d = '0;
      fall_d = fall_inc;
      if (fall_inc >= fall_goal) begin
        if (peaks_q == '0) begin
          first_d = idx_q;
        end
        last_d = idx_q;
        if (peaks_q != pwpi_pkg::PeaksMax) begin
          peaks_d = peaks_q + CW'(1);
        end
        armed_d = 1'b0;
      end
    end else if (neg) begin
      rise_d = '0;
    end

    win_end = ({1'b0, idx_q} + (CW + 1)'(1)) >= {1'b0, wlen_q};
    multi   = peaks_d >= CW'(2);
    span    = (last_d >= first_d) ? last_d - first_d : '0;
  end

  pwpi_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (span),
    .divisor_i  (peaks_d - CW'(1)),
    .quotient_o (div_quo),
    .stat_o     (div_stat)
  );

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      pwpi_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = pwpi_pkg::ST_MUL;
        end
      end
      pwpi_pkg::ST_MUL: begin
        if (mul_stat.done) begin
          state_d = pwpi_pkg::ST_UPD;
        end
      end
      pwpi_pkg::ST_UPD: begin
        if (!win_end) begin
          state_d = pwpi_pkg::ST_IDLE;
        end else if (multi) begin
          state_d = pwpi_pkg::ST_DIV;
        end else begin
          state_d = pwpi_pkg::ST_EMIT;
        end
      end
      pwpi_pkg::ST_DIV: begin
        if (div_stat.done) begin
          state_d = pwpi_pkg::ST_EMIT;
        end
      end
      pwpi_pkg::ST_EMIT: begin
        if (out_free) begin
          state_d = pwpi_pkg::ST_IDLE;
        end
      end
      default: state_d = pwpi_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = 1'b1;
    mul_start  = 1'b0;
    div_start  = 1'b0;
    emit_load  = 1'b0;
    case (state_q)
      pwpi_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        mul_start  = in_valid_i;
      end
      pwpi_pkg::ST_UPD:  div_start = win_end && multi;
      pwpi_pkg::ST_EMIT: emit_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pwpi_pkg::ST_IDLE;
      gain_q      <= pwpi_pkg::GainReset;
      wlen_q      <= pwpi_pkg::WindowReset;
      spike_q     <= pwpi_pkg::SpikeReset;
      rise_need_q <= pwpi_pkg::RunReset;
      fall_need_q <= pwpi_pkg::RunReset;
      acc_q         <= '0;
      up_q          <= 1'b0;
      prev_smooth_q <= '0;
      prev_slope_q  <= '0;
      rise_q        <= '0;
      fall_q        <= '0;
      armed_q       <= 1'b0;
      idx_q         <= '0;
      peaks_q       <= '0;
      first_q       <= '0;
      last_q        <= '0;
      res_count_q   <= '0;
      res_valid_q   <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          pwpi_pkg::CFG_FILTER_GAIN:   gain_q      <= cfg_data_i;
          pwpi_pkg::CFG_WINDOW_LENGTH: wlen_q      <= cfg_data_i[CW-1:0];
          pwpi_pkg::CFG_SPIKE_LIMIT:   spike_q     <= cfg_data_i;
          pwpi_pkg::CFG_RISE_NEEDED:   rise_need_q <= cfg_data_i[RW-1:0];
          pwpi_pkg::CFG_FALL_NEEDED:   fall_need_q <= cfg_data_i[RW-1:0];
          default: ;
        endcase
      end
      if (mul_start) begin
        up_q <= err_up;
      end
      if (state_q == pwpi_pkg::ST_MUL && mul_stat.done) begin
        acc_q <= up_q ? acc_q + mul_step : acc_q - mul_step;
      end
      if (state_q == pwpi_pkg::ST_UPD) begin
        if (win_end) begin
          res_count_q   <= peaks_d;
          res_valid_q   <= multi;
          acc_q         <= '0;
          prev_smooth_q <= '0;
          prev_slope_q  <= '0;
          rise_q        <= '0;
          fall_q        <= '0;
          armed_q       <= 1'b0;
          idx_q         <= '0;
          peaks_q       <= '0;
          first_q       <= '0;
          last_q        <= '0;
        end else begin
          prev_smooth_q <= smooth;
          prev_slope_q  <= slope;
          rise_q        <= rise_d;
          fall_q        <= fall_d;
          armed_q       <= armed_d;
          idx_q         <= idx_q + CW'(1);
          peaks_q       <= peaks_d;
          first_q       <= first_d;
          last_q        <= last_d;
        end
      end
      if (emit_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_load) begin
      out_count_q  <= res_count_q;
      out_mean_q   <= res_valid_q ? div_quo : '0;
      out_ivalid_q <= res_valid_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign peak_count_o     = out_count_q;
  assign mean_interval_o  = out_mean_q;
  assign interval_valid_o = out_ivalid_q;

  `include "ppg_window_peak_interval_unit_assert.svh"

  `PWPI_ASSERT(a_units_exclusive, !(mul_stat.busy && div_stat.busy), "multiplier and divider overlap")
  `PWPI_ASSERT_NEXT(a_accept_starts_mul, in_valid_i && !in_stall_o, mul_stat.busy, "accepted sample did not start the multiplier")
  `PWPI_ASSERT(a_peak_order, first_q <= last_q, "first peak index beyond last peak index")
  `PWPI_ASSERT(a_mean_zero, !(out_valid_o && !interval_valid_o) || (mean_interval_o == '0), "mean interval nonzero without two peaks")

endmodule
